@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: port behaviour");

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed: reset behaviour");

`endif

@@ hdl/tfes_pkg.sv @@
package tfes_pkg;

   localparam int unsigned LEN_W = 10;
   localparam int unsigned POS_W = 14;
   localparam int unsigned STEP_W = 8;
   localparam int unsigned ALPHA_W = 8;

   localparam logic [LEN_W-1:0] MAX_TEXT_LENGTH = 10'd1023;
   localparam logic [POS_W-1:0] HOLD_BASE = 14'd720;
   localparam logic [POS_W-1:0] RAMP_TOP = 14'd256;
   localparam logic [POS_W-1:0] FULL_ALPHA = 14'd255;
   localparam logic [POS_W-1:0] CUT_POSITION = 14'd976;   // hold base plus ramp top

   typedef enum logic [1:0] {
      KIND_SHOW        = 2'd0,
      KIND_RENDER_DONE = 2'd1,
      KIND_TICK        = 2'd2,
      KIND_UNUSED      = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [LEN_W-1:0]    text_length;
      logic                immediate;
      logic [STEP_W-1:0]   step_amount;
   } item_type;

   typedef struct packed {
      logic                alpha_valid;
      logic [ALPHA_W-1:0]  alpha;
      logic                idle;
      logic                render_request;
   } result_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      clamp_len = (len > MAX_TEXT_LENGTH) ? MAX_TEXT_LENGTH : len;
   endfunction

   // end point = length * 8 + 720
   function automatic logic [POS_W-1:0] fade_end_of(input logic [LEN_W-1:0] len);
      fade_end_of = POS_W'({len, 3'b000}) + HOLD_BASE;
   endfunction

endpackage

@@ hdl/text_fade_envelope_sequencer_unit.sv @@
// Caption alpha envelope sequencer. Each item on req_ (show request, render-done
// notice, tick or unused kind) gives exactly one result item on rsp_, in order.
// One item is taken per clock cycle when the result side keeps rsp_tready high;
// an item goes from the input register through the state update into the result
// register, and its result is offered on rsp_ once it is in the result register.
// The rate is set by the caption state update, which is combinational. A stalled
// result holds its item while one more request waits in the input register.
module text_fade_envelope_sequencer_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // text_length[9:0], immediate[10], step_amount[18:11]
   input  logic [1:0]   req_tuser,   // kind[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // alpha[7:0], idle[8], render_request[9]
   output logic         rsp_tuser    // alpha_valid
);

   logic                  req_valid_ff, req_valid_in;
   tfes_pkg::item_type    req_item_ff, req_item_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tfes_pkg::result_type  rsp_result_ff;
   tfes_pkg::result_type  core_result;
   logic                  out_free;
   logic                  fire;
   logic                  take;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = req_valid_ff && out_free;
   assign req_tready = !req_valid_ff || fire;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      req_valid_in             = take || (req_valid_ff && !fire);
      req_item_in.kind         = tfes_pkg::kind_type'(req_tuser);
      req_item_in.text_length  = req_tdata[9:0];
      req_item_in.immediate    = req_tdata[10];
      req_item_in.step_amount  = req_tdata[18:11];
      rsp_valid_in             = fire || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_item_ff <= req_item_in;
      end
      if (fire) begin
         rsp_result_ff <= core_result;
      end
   end

   tfes_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (req_item_ff),
      .result (core_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_result_ff.alpha_valid;
   assign rsp_tdata  = {6'b000000, rsp_result_ff.render_request, rsp_result_ff.idle,
                        rsp_result_ff.alpha};

endmodule

@@ hdl/tfes_core.sv @@
module tfes_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  tfes_pkg::item_type   item,
   output tfes_pkg::result_type result
);

   logic                          active_ff, active_in;
   logic                          queued_valid_ff, queued_valid_in;
   logic [tfes_pkg::LEN_W-1:0]    queued_length_ff, queued_length_in;
   logic [tfes_pkg::POS_W-1:0]    position_ff, position_in;
   logic [tfes_pkg::POS_W-1:0]    fade_end_ff, fade_end_in;
   logic                          render_pending_ff, render_pending_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff         <= 1'b0;
         queued_valid_ff   <= 1'b0;
         queued_length_ff  <= '0;
         position_ff       <= '0;
         fade_end_ff       <= '0;
         render_pending_ff <= 1'b0;
      end else if (fire) begin
         active_ff         <= active_in;
         queued_valid_ff   <= queued_valid_in;
         queued_length_ff  <= queued_length_in;
         position_ff       <= position_in;
         fade_end_ff       <= fade_end_in;
         render_pending_ff <= render_pending_in;
      end
   end

   always_comb begin
      logic [tfes_pkg::LEN_W-1:0]   len;
      logic [tfes_pkg::POS_W-1:0]   diff;
      logic                         go;
      len               = tfes_pkg::clamp_len(item.text_length);
      diff              = '0;
      go                = 1'b1;
      active_in         = active_ff;
      queued_valid_in   = queued_valid_ff;
      queued_length_in  = queued_length_ff;
      position_in       = position_ff;
      fade_end_in       = fade_end_ff;
      render_pending_in = render_pending_ff;
      result            = '0;
      case (item.kind)
         tfes_pkg::KIND_SHOW: begin
            if (!active_ff) begin
               active_in         = 1'b1;
               queued_valid_in   = 1'b0;
               position_in       = '0;
               fade_end_in       = tfes_pkg::fade_end_of(len);
               render_pending_in = 1'b1;
            end else begin
               queued_valid_in  = 1'b1;
               queued_length_in = len;
               if (item.immediate) begin
                  fade_end_in = tfes_pkg::HOLD_BASE;
                  position_in = tfes_pkg::CUT_POSITION;
               end
            end
         end
         tfes_pkg::KIND_RENDER_DONE: begin
            render_pending_in = 1'b0;
         end
         tfes_pkg::KIND_TICK: begin
            if (!active_ff) begin
               if (queued_valid_ff) begin
                  active_in         = 1'b1;
                  queued_valid_in   = 1'b0;
                  position_in       = '0;
                  fade_end_in       = tfes_pkg::fade_end_of(queued_length_ff);
                  render_pending_in = 1'b1;
               end else begin
                  position_in = '0;
                  result.idle = 1'b1;
                  go          = 1'b0;
               end
            end
            if (go && !render_pending_in) begin
               position_in = position_in + tfes_pkg::POS_W'(item.step_amount);
               diff        = position_in - fade_end_in;
               if (position_in < tfes_pkg::RAMP_TOP) begin
                  result.alpha_valid = 1'b1;
                  result.alpha       = position_in[tfes_pkg::ALPHA_W-1:0];
               end else if (position_in < fade_end_in) begin
                  result.alpha_valid = 1'b1;
                  result.alpha       = tfes_pkg::FULL_ALPHA[tfes_pkg::ALPHA_W-1:0];
               end else if (diff < tfes_pkg::FULL_ALPHA) begin
                  result.alpha_valid = 1'b1;
                  result.alpha       = tfes_pkg::FULL_ALPHA[tfes_pkg::ALPHA_W-1:0]
                                       - diff[tfes_pkg::ALPHA_W-1:0];
               end else if (queued_valid_in) begin
                  // fade-out finished, next caption waits for its glyphs
                  active_in         = 1'b1;
                  queued_valid_in   = 1'b0;
                  position_in       = '0;
                  fade_end_in       = tfes_pkg::fade_end_of(queued_length_in);
                  render_pending_in = 1'b1;
               end else begin
                  active_in   = 1'b0;
                  position_in = '0;
                  result.idle = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      result.render_request = render_pending_in;
   end

endmodule

@@ hdl/tfes_checker.sv @@
`include "assert_macros.svh"

module tfes_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [15:0]  rsp_tdata,
   input logic         rsp_tuser
);

   // an alpha and an idle report never share one item
   `ASSERT_CLK_RST(a_alpha_idle_excl, clock, reset, rsp_tvalid |-> !(rsp_tuser && rsp_tdata[8]))

   // no alpha means a zero alpha field
   `ASSERT_CLK_RST(a_alpha_zero, clock, reset, (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[7:0] == 8'd0))

   // alpha and idle only come out once the glyphs are drawn
   `ASSERT_CLK_RST(a_no_render_pending, clock, reset, (rsp_tvalid && (rsp_tuser || rsp_tdata[8])) |-> !rsp_tdata[9])

   // a stalled result holds
   `ASSERT_CLK_RST(a_stall_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))

   // nothing is offered straight after reset
   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

bind text_fade_envelope_sequencer_unit tfes_checker u_tfes_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CHAR_TICKS = 8;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;   // text_length[9:0], immediate[10], step_amount[18:11]
   logic [1:0]   req_tuser = '0;   // kind[1:0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  rsp_tdata;        // alpha[7:0], idle[8], render_request[9]
   logic         rsp_tuser;        // alpha_valid

   text_fade_envelope_sequencer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // caption state as the block should hold it
   logic                       cap_active = 1'b0;
   logic                       cap_queued = 1'b0;
   logic [tfes_pkg::LEN_W-1:0] cap_queued_len = '0;
   logic [tfes_pkg::POS_W-1:0] cap_pos = '0;
   logic [tfes_pkg::POS_W-1:0] cap_fade_end = '0;
   logic                       cap_render_pending = 1'b0;

   tfes_pkg::result_type  alpha_expected[$];
   int                    mismatch_count = 0;
   int                    live_items = 0;
   int                    burst_left = 0;
   logic [9:0]            drain_cycle = '0;

   function automatic void begin_caption(input logic [tfes_pkg::LEN_W-1:0] len);
      cap_active         = 1'b1;
      cap_queued         = 1'b0;
      cap_pos            = '0;
      cap_fade_end       = tfes_pkg::POS_W'(len) * tfes_pkg::POS_W'(CHAR_TICKS)
                           + tfes_pkg::HOLD_BASE;
      cap_render_pending = 1'b1;
   endfunction

   function automatic tfes_pkg::result_type envelope_step(
         input tfes_pkg::kind_type kind,
         input logic [tfes_pkg::LEN_W-1:0] len,
         input logic imm,
         input logic [tfes_pkg::STEP_W-1:0] step);
      tfes_pkg::result_type        r;
      logic                        go;
      logic [tfes_pkg::POS_W-1:0]  past_end;
      r  = '0;
      go = 1'b1;
      case (kind)
         tfes_pkg::KIND_SHOW: begin
            if (!cap_active) begin
               begin_caption(len);
            end else begin
               cap_queued     = 1'b1;
               cap_queued_len = len;
               if (imm) begin
                  cap_fade_end = tfes_pkg::HOLD_BASE;
                  cap_pos      = tfes_pkg::CUT_POSITION;
               end
            end
         end
         tfes_pkg::KIND_RENDER_DONE: begin
            cap_render_pending = 1'b0;
         end
         tfes_pkg::KIND_TICK: begin
            if (!cap_active) begin
               if (cap_queued) begin
                  begin_caption(cap_queued_len);
               end else begin
                  cap_pos = '0;
                  r.idle  = 1'b1;
                  go      = 1'b0;
               end
            end
            if (go && !cap_render_pending) begin
               cap_pos  = cap_pos + tfes_pkg::POS_W'(step);
               past_end = cap_pos - cap_fade_end;
               if (cap_pos < tfes_pkg::RAMP_TOP) begin
                  r.alpha_valid = 1'b1;
                  r.alpha       = cap_pos[tfes_pkg::ALPHA_W-1:0];
               end else if (cap_pos < cap_fade_end) begin
                  r.alpha_valid = 1'b1;
                  r.alpha       = tfes_pkg::FULL_ALPHA[tfes_pkg::ALPHA_W-1:0];
               end else if (past_end < tfes_pkg::FULL_ALPHA) begin
                  r.alpha_valid = 1'b1;
                  r.alpha       = tfes_pkg::ALPHA_W'(tfes_pkg::FULL_ALPHA - past_end);
               end else if (cap_queued) begin
                  begin_caption(cap_queued_len);
               end else begin
                  cap_active = 1'b0;
                  cap_pos    = '0;
                  r.idle     = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      r.render_request = cap_render_pending;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 20)
         $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
   endtask

   task automatic check_result();
      tfes_pkg::result_type want;
      if (alpha_expected.size() == 0) begin
         report_mismatch("result item with none pending", 1, 0);
      end else begin
         want = alpha_expected.pop_front();
         if (rsp_tuser !== want.alpha_valid)
            report_mismatch("alpha_valid", rsp_tuser, want.alpha_valid);
         if (rsp_tdata[7:0] !== want.alpha)
            report_mismatch("alpha", rsp_tdata[7:0], want.alpha);
         if (rsp_tdata[8] !== want.idle)
            report_mismatch("idle", rsp_tdata[8], want.idle);
         if (rsp_tdata[9] !== want.render_request)
            report_mismatch("render_request", rsp_tdata[9], want.render_request);
      end
   endtask

   // result side: checks, then picks next ready from a slowly rotating pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_result();
      drain_cycle <= drain_cycle + 1'b1;
      case (drain_cycle[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= (drain_cycle[2:0] != 3'd6) && (drain_cycle[4:3] != 2'd1);
         default: rsp_tready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   task automatic send_item(input tfes_pkg::kind_type kind,
                            input logic [tfes_pkg::LEN_W-1:0] len,
                            input logic imm,
                            input logic [tfes_pkg::STEP_W-1:0] step);
      int gap;
      if (!(kind == tfes_pkg::KIND_UNUSED
            || (kind == tfes_pkg::KIND_RENDER_DONE && !cap_render_pending)))
         live_items++;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'd0, step, imm, len};
      do @(posedge clock); while (!req_tready);
      alpha_expected.push_back(envelope_step(kind, len, imm, step));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(0, 20);
      end
   endtask

   task automatic test_idle_and_noise();
      send_item(tfes_pkg::KIND_TICK, '0, 1'b0, 8'd255);
      send_item(tfes_pkg::KIND_RENDER_DONE, '0, 1'b0, '0);
      send_item(tfes_pkg::KIND_UNUSED, 10'd1023, 1'b1, 8'd255);
   endtask

   task automatic test_single_envelope();
      send_item(tfes_pkg::KIND_SHOW, 10'd0, 1'b0, '0);
      send_item(tfes_pkg::KIND_TICK, '0, 1'b0, 8'd255);      // held off: glyphs not drawn yet
      send_item(tfes_pkg::KIND_RENDER_DONE, '0, 1'b0, '0);
      send_item(tfes_pkg::KIND_TICK, '0, 1'b0, 8'd0);
      repeat (4) send_item(tfes_pkg::KIND_TICK, '0, 1'b0, 8'd255);
   endtask

   task automatic test_queue_and_cut();
      send_item(tfes_pkg::KIND_SHOW, 10'd1023, 1'b0, '0);
      send_item(tfes_pkg::KIND_SHOW, 10'd2, 1'b1, '0);       // cut while render still pending
      send_item(tfes_pkg::KIND_RENDER_DONE, '0, 1'b0, '0);
      send_item(tfes_pkg::KIND_TICK, '0, 1'b0, 8'd0);        // fade-out over, queued one starts
      send_item(tfes_pkg::KIND_RENDER_DONE, '0, 1'b0, '0);
      send_item(tfes_pkg::KIND_TICK, '0, 1'b0, 8'd200);
      send_item(tfes_pkg::KIND_SHOW, 10'd3, 1'b0, '0);
      send_item(tfes_pkg::KIND_SHOW, 10'd1, 1'b0, '0);       // replaces the waiting one
      repeat (3) send_item(tfes_pkg::KIND_TICK, '0, 1'b0, 8'd255);
      send_item(tfes_pkg::KIND_TICK, '0, 1'b0, 8'd100);
      send_item(tfes_pkg::KIND_RENDER_DONE, '0, 1'b0, '0);
      repeat (4) send_item(tfes_pkg::KIND_TICK, '0, 1'b0, 8'd255);
   endtask

   task automatic test_random_captions(input int target);
      int                          pick;
      logic [tfes_pkg::LEN_W-1:0]  len;
      logic [tfes_pkg::STEP_W-1:0] step;
      logic                        imm;
      live_items = 0;
      while (live_items < target) begin
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 19) == 0) ? tfes_pkg::LEN_W'($urandom_range(0, 1023))
                                             : tfes_pkg::LEN_W'($urandom_range(0, 40));
         step = ($urandom_range(0, 9) == 0) ? tfes_pkg::STEP_W'($urandom())
                                            : tfes_pkg::STEP_W'($urandom_range(96, 255));
         imm  = 1'($urandom_range(0, 1));
         if (cap_render_pending && pick < 70)
            send_item(tfes_pkg::KIND_RENDER_DONE, len, imm, step);
         else if (!cap_active && pick < 60)
            send_item(tfes_pkg::KIND_SHOW, len, imm, step);
         else if (pick < 8)
            send_item(tfes_pkg::KIND_SHOW, len, $urandom_range(0, 2) == 0, step);
         else if (pick < 10)
            send_item(tfes_pkg::KIND_RENDER_DONE, len, imm, step);
         else if (pick < 12)
            send_item(tfes_pkg::KIND_UNUSED, len, imm, step);
         else
            send_item(tfes_pkg::KIND_TICK, len, imm, step);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_idle_and_noise();
      test_single_envelope();
      test_queue_and_cut();
      test_random_captions(550);
      req_tvalid <= 1'b0;
      while (alpha_expected.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
